>>> sv/adts_header_deframer_unit_defines.svh
// assertion macros for the adts header deframer
`ifndef ADTS_HEADER_DEFRAMER_UNIT_DEFINES_SVH
`define ADTS_HEADER_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define ADTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("adts deframer assertion failed");

// next-cycle implication, checked out of reset
`define ADTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("adts deframer assertion failed");

`else

`define ADTS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ADTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/adts_pkg.sv
// types and codes shared by the adts header deframer
package adts_pkg;

    // result kinds
    localparam logic [1:0] KIND_INFO    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NO_SYNC      = 2'd0;
    localparam logic [1:0] ERR_SHORT_HEADER = 2'd1;
    localparam logic [1:0] ERR_SHORT_PAYLOAD = 2'd2;
    localparam logic [1:0] ERR_LEN_BELOW_HDR = 2'd3;

    // header position codes
    localparam logic [3:0] POS_SYNC0   = 4'd0;
    localparam logic [3:0] POS_SYNC1   = 4'd1;
    localparam logic [3:0] POS_HDR2    = 4'd2;
    localparam logic [3:0] POS_HDR3    = 4'd3;
    localparam logic [3:0] POS_HDR4    = 4'd4;
    localparam logic [3:0] POS_HDR5    = 4'd5;
    localparam logic [3:0] POS_HDR6    = 4'd6;
    localparam logic [3:0] POS_CRC0    = 4'd7;
    localparam logic [3:0] POS_CRC1    = 4'd8;
    localparam logic [3:0] POS_PAYLOAD = 4'd9;

    // header sizes in bytes
    localparam logic [12:0] HDR_LEN_PLAIN = 13'd7;
    localparam logic [12:0] HDR_LEN_CRC   = 13'd9;

    localparam logic [7:0] SYNC_BYTE = 8'hff;
    localparam logic [3:0] SYNC_NIBBLE = 4'hf;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [1:0]  object_type;
        logic [3:0]  rate_index;
        logic [2:0]  channel_config;
        logic [12:0] frame_bytes;
        logic        crc_present;
        logic [1:0]  flv_rate;
        logic        stereo;
        logic [1:0]  error_code;
        logic        last;
    } t_result;

endpackage

>>> sv/adts_header_deframer_unit.sv
// adts header deframer top level: header capture, payload pass-through, output skid
//
// Takes an ADTS AAC stream one byte per word on the slave side, s_axis_tlast
// marking the last byte of an input buffer. Each frame must open with the sync
// word 0xFFF; the 7-byte header (9 with CRC, CRC not checked) is captured and
// one frame-info word goes out, then the payload bytes pass through with
// m_axis_tlast on the last one. Errors (no sync, short header, short payload,
// length below header size) give one error word and the block discards input
// up to the end of the current buffer, starting fresh on the next one. Every
// input byte is decided in the cycle it is accepted, so the block takes one
// byte per clock while s_axis_tready is high and gives at most one result
// word per byte; the result lands in an output register backed by a one-word
// skid register, so s_axis_tready only drops when both are full under
// back-pressure.
`include "adts_header_deframer_unit_defines.svh"

module adts_header_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // buffer_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [9:8] object_type, [13:10] rate_index,
    // [16:14] channel_config, [29:17] frame_bytes, [30] crc_present,
    // [32:31] flv_rate, [33] stereo, [35:34] error_code, [39:36] zero
    output logic [39:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last payload byte of a frame
);
    import adts_pkg::*;

    // parser state
    logic [3:0]  r_pos, n_pos;
    logic [12:0] r_remaining, n_remaining;
    logic [1:0]  r_profile, n_profile;
    logic [3:0]  r_rate_idx, n_rate_idx;
    logic [2:0]  r_channels, n_channels;
    logic [12:0] r_length, n_length;
    logic        r_crc_flag, n_crc_flag;
    logic        r_err_hold, n_err_hold;

    // output register and skid register
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        in_accept;
    logic        out_take;
    logic        res_valid;
    t_result     res;
    logic        at_end;
    logic [7:0]  in_byte;
    logic [12:0] hdr_size;
    logic [12:0] rem;
    logic [1:0]  flv_code;

    assign in_byte   = s_axis_tdata;
    assign at_end    = s_axis_tlast;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_take  = r_out_valid && m_axis_tready;

    // ready only depends on the skid slot being free
    assign s_axis_tready = !r_skid_valid;

    // header size and remaining payload for the finishing byte
    assign hdr_size = (r_pos == POS_CRC1) ? HDR_LEN_CRC : HDR_LEN_PLAIN;
    assign rem      = r_length - hdr_size;

    // rate class from sampling frequency index
    always_comb begin
        case (r_rate_idx) inside
            [4'd11:4'd12]: flv_code = 2'd0;
            [4'd8:4'd10]:  flv_code = 2'd1;
            [4'd5:4'd7]:   flv_code = 2'd2;
            default:       flv_code = 2'd3;
        endcase
    end

    // per-byte decision: next state and the result word, if any
    always_comb begin
        n_pos       = r_pos;
        n_remaining = r_remaining;
        n_profile   = r_profile;
        n_rate_idx  = r_rate_idx;
        n_channels  = r_channels;
        n_length    = r_length;
        n_crc_flag  = r_crc_flag;
        n_err_hold  = r_err_hold;
        res_valid   = 1'b0;
        res         = '0;

        if (r_err_hold) begin
            // discard up to the end of the buffer
            if (at_end) begin
                n_err_hold = 1'b0;
                n_pos      = POS_SYNC0;
            end
        end else begin
            case (r_pos)
                POS_SYNC0: begin
                    if (at_end) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_SHORT_HEADER;
                    end else if (in_byte != SYNC_BYTE) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_NO_SYNC;
                    end else begin
                        n_pos = POS_SYNC1;
                    end
                end
                POS_SYNC1: begin
                    if (at_end) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_SHORT_HEADER;
                    end else if (in_byte[7:4] != SYNC_NIBBLE) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_NO_SYNC;
                    end else begin
                        n_crc_flag = ~in_byte[0];
                        n_pos      = POS_HDR2;
                    end
                end
                POS_HDR2: begin
                    if (at_end) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_SHORT_HEADER;
                    end else begin
                        n_profile  = in_byte[7:6];
                        n_rate_idx = in_byte[5:2];
                        n_channels = {in_byte[0], 2'b00};
                        n_pos      = POS_HDR3;
                    end
                end
                POS_HDR3: begin
                    if (at_end) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_SHORT_HEADER;
                    end else begin
                        n_channels = {r_channels[2], in_byte[7:6]};
                        n_length   = {in_byte[1:0], 11'd0};
                        n_pos      = POS_HDR4;
                    end
                end
                POS_HDR4: begin
                    if (at_end) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_SHORT_HEADER;
                    end else begin
                        n_length = {r_length[12:11], in_byte, 3'd0};
                        n_pos    = POS_HDR5;
                    end
                end
                POS_HDR5: begin
                    if (at_end) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_SHORT_HEADER;
                    end else begin
                        n_length = {r_length[12:3], in_byte[7:5]};
                        n_pos    = POS_HDR6;
                    end
                end
                POS_CRC0: begin
                    if (at_end) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_SHORT_HEADER;
                    end else begin
                        n_pos = POS_CRC1;
                    end
                end
                POS_HDR6, POS_CRC1: begin
                    if ((r_pos == POS_HDR6) && r_crc_flag) begin
                        // crc follows, skip it
                        if (at_end) begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_SHORT_HEADER;
                        end else begin
                            n_pos = POS_CRC0;
                        end
                    end else if (r_length < hdr_size) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_LEN_BELOW_HDR;
                    end else if ((rem != 13'd0) && at_end) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_SHORT_PAYLOAD;
                    end else begin
                        // header complete: frame info word
                        res_valid          = 1'b1;
                        res.kind           = KIND_INFO;
                        res.object_type    = (r_profile == 2'd3) ? 2'd0 : (r_profile + 2'd1);
                        res.rate_index     = r_rate_idx;
                        res.channel_config = r_channels;
                        res.frame_bytes    = r_length;
                        res.crc_present    = r_crc_flag;
                        res.flv_rate       = flv_code;
                        res.stereo         = (r_channels >= 3'd2);
                        n_remaining        = rem;
                        n_pos              = (rem != 13'd0) ? POS_PAYLOAD : POS_SYNC0;
                    end
                end
                default: begin
                    // payload phase, also covers unused position codes
                    if (r_remaining <= 13'd1) begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.payload_byte = in_byte;
                        res.last         = 1'b1;
                        n_remaining      = 13'd0;
                        n_pos            = POS_SYNC0;
                    end else if (at_end) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_SHORT_PAYLOAD;
                    end else begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.payload_byte = in_byte;
                        n_remaining      = r_remaining - 13'd1;
                    end
                end
            endcase

            // any error word resets the parser and may start a discard run
            if (res_valid && (res.kind == KIND_ERROR)) begin
                n_pos       = POS_SYNC0;
                n_remaining = 13'd0;
                n_err_hold  = !at_end;
            end
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_SYNC0;
            r_remaining <= 13'd0;
            r_profile   <= 2'd0;
            r_rate_idx  <= 4'd0;
            r_channels  <= 3'd0;
            r_length    <= 13'd0;
            r_crc_flag  <= 1'b0;
            r_err_hold  <= 1'b0;
        end else if (in_accept) begin
            r_pos       <= n_pos;
            r_remaining <= n_remaining;
            r_profile   <= n_profile;
            r_rate_idx  <= n_rate_idx;
            r_channels  <= n_channels;
            r_length    <= n_length;
            r_crc_flag  <= n_crc_flag;
            r_err_hold  <= n_err_hold;
        end
    end

    // output register with skid slot behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_take || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_accept && res_valid;
                end
            end else if (in_accept && res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept && res_valid) begin
                r_out <= res;
            end
        end else if (in_accept && res_valid) begin
            r_skid <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {4'd0, r_out.error_code, r_out.stereo, r_out.flv_rate,
                            r_out.crc_present, r_out.frame_bytes, r_out.channel_config,
                            r_out.rate_index, r_out.object_type, r_out.payload_byte};

    // skid slot only fills behind a held output word
    `ADTS_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // discarding always restarts at the sync byte
    `ADTS_ASSERT_IMPL(a_hold_at_sync, i_clk, i_rst_n, r_err_hold, r_pos == POS_SYNC0)
    // payload phase always has at least one byte due
    `ADTS_ASSERT_IMPL(a_payload_due, i_clk, i_rst_n, r_pos == POS_PAYLOAD,
                      r_remaining != 13'd0)
    // a final payload byte sends the parser back to the sync byte
    `ADTS_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n,
                      in_accept && res_valid && res.last, r_pos == POS_SYNC0)

endmodule
